// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Operation and error codes, port field widths and the command bundle that
// the controller sends to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int FUNC_W = 3;
    localparam int PORT_W = 32;
    localparam int OCC_W  = 5;
    localparam int ERR_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REM_BACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PEEK      = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic fetch;
        logic load_out;
    } dq_cmd_t;

endpackage

// ===== rtl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl: operation sequencer
// Steps each accepted operation through execute, fetch and respond, and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath: element store, pointers and result register
// Holds the circular buffer with one write port and two registered read
// ports, the head pointer and element count, and the result payload.
// ----------------------------------------------------------------------------
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dq_cmd_t           cmd,
    input  logic [FUNC_W-1:0] func,
    input  logic [PORT_W-1:0] item_value,
    output logic [PORT_W-1:0] removed_value,
    output logic [PORT_W-1:0] front_value,
    output logic [PORT_W-1:0] back_value,
    output logic [OCC_W-1:0]  occupancy,
    output logic              is_empty,
    output logic [ERR_W-1:0]  error_code
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [ERR_W-1:0]      err_reg;
    logic [ERR_W-1:0]      err_next;
    logic                  rem_ok_reg;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic [DATA_WIDTH-1:0] rd_a_reg;
    logic [DATA_WIDTH-1:0] rd_b_reg;

    logic [PORT_W-1:0]     removed_value_reg;
    logic [PORT_W-1:0]     front_value_reg;
    logic [PORT_W-1:0]     back_value_reg;
    logic [OCC_W-1:0]      occupancy_reg;
    logic                  is_empty_reg;
    logic [ERR_W-1:0]      error_code_reg;

    logic          ins_front;
    logic          ins_back;
    logic          rem_front;
    logic          rem_back;
    logic          full;
    logic          empty;
    logic          ins_ok;
    logic          rem_ok;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] back_slot;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW + 1)'(base) + (AW + 1)'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        ins_front = (func_reg == FUNC_INS_FRONT);
        ins_back  = (func_reg == FUNC_INS_BACK);
        rem_front = (func_reg == FUNC_REM_FRONT);
        rem_back  = (func_reg == FUNC_REM_BACK);
        full      = (count_reg == DEPTH_C);
        empty     = (count_reg == '0);
        ins_ok    = (ins_front || ins_back) && !full;
        rem_ok    = (rem_front || rem_back) && !empty;

        head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
        head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        tail_slot = wrap_add(head_reg, count_reg);
        back_slot = wrap_add(head_reg, empty ? count_reg : count_reg - 1'b1);

        if ((ins_front || ins_back) && full)
        begin
            err_next = ERR_FULL;
        end
        else if (!(ins_front || ins_back) && empty)
        begin
            err_next = ERR_EMPTY;
        end
        else
        begin
            err_next = ERR_OK;
        end

        head_next = head_reg;
        if (ins_ok && ins_front)
        begin
            head_next = head_dec;
        end
        else if (rem_ok && rem_front)
        begin
            head_next = head_inc;
        end

        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rem_ok)
        begin
            count_next = count_reg - 1'b1;
        end

        we      = cmd.exec && ins_ok;
        waddr   = ins_front ? head_dec : tail_slot;
        raddr_a = (cmd.exec && rem_back) ? back_slot : head_reg;
        raddr_b = back_slot;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= value_reg;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg  <= func;
            value_reg <= DATA_WIDTH'(item_value);
        end
        if (cmd.exec)
        begin
            err_reg    <= err_next;
            rem_ok_reg <= rem_ok;
        end
        if (cmd.fetch)
        begin
            removed_reg <= rem_ok_reg ? rd_a_reg : '0;
        end
        if (cmd.load_out)
        begin
            removed_value_reg <= PORT_W'(removed_reg);
            front_value_reg   <= empty ? '0 : PORT_W'(rd_a_reg);
            back_value_reg    <= empty ? '0 : PORT_W'(rd_b_reg);
            occupancy_reg     <= OCC_W'(count_reg);
            is_empty_reg      <= empty;
            error_code_reg    <= err_reg;
        end
    end

    assign removed_value = removed_value_reg;
    assign front_value   = front_value_reg;
    assign back_value    = back_value_reg;
    assign occupancy     = occupancy_reg;
    assign is_empty      = is_empty_reg;
    assign error_code    = error_code_reg;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue on a circular buffer
// Inserts or removes at either end, or peeks, and reports the removed value,
// both end values, occupancy and an error code for every operation.
//
//   Channel  Direction  Handshake            Payload
//   in       receive    in_valid / in_stall  func, item_value
//   out      send       out_valid/out_stall  removed_value, front_value,
//                                            back_value, occupancy,
//                                            is_empty, error_code
//
// From acceptance to a loaded result, each operation passes through execute
// (update the pointers, write or read the store), fetch (registered reads of
// the new front and back entries) and respond (form the result).
// The next operation is accepted while a result still waits in the output
// register. Reset empties the queue at once; the store needs no clearing.
// A stalled output holds the block in its respond step until the register frees.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [PORT_W-1:0] item_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PORT_W-1:0] removed_value,
    output logic [PORT_W-1:0] front_value,
    output logic [PORT_W-1:0] back_value,
    output logic [OCC_W-1:0]  occupancy,
    output logic              is_empty,
    output logic [ERR_W-1:0]  error_code
);

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .item_value    (item_value),
        .removed_value (removed_value),
        .front_value   (front_value),
        .back_value    (back_value),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .error_code    (error_code)
    );

endmodule

// ===== rtl/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the top-level ports and flags results that contradict each other
// or a handshake that misbehaves.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [PORT_W-1:0] removed_value,
    input logic [PORT_W-1:0] front_value,
    input logic [PORT_W-1:0] back_value,
    input logic [OCC_W-1:0]  occupancy,
    input logic              is_empty,
    input logic [ERR_W-1:0]  error_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(removed_value)
            && $stable(front_value) && $stable(back_value)
            && $stable(occupancy) && $stable(error_code))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while an operation is in flight");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> occupancy == '0 && front_value == '0
            && back_value == '0)
        else $error("empty queue reports contents");

    a_err_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_OK |-> removed_value == '0)
        else $error("rejected operation returned a value");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_FULL |-> !is_empty)
        else $error("full error on an empty queue");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);
